@@ sv/mcog_pkg.sv @@
// shared types, constants and helper functions of the circle outline generator
package mcog_pkg;

  // internal coordinate width, ports stay 16 bits
  localparam int COORD_BITS = 16;
  localparam int PORT_W     = 16;
  localparam int RADIUS_W   = 14;
  localparam int OFF_W      = 15;
  localparam int ERR_W      = 18;
  localparam int NUM_BEATS  = 8;
  localparam int BEAT_W     = $clog2(NUM_BEATS);
  localparam logic [BEAT_W-1:0] BEAT_LAST = BEAT_W'(NUM_BEATS - 1);

  typedef logic [COORD_BITS-1:0] coord_t;
  typedef logic [OFF_W-1:0]      off_t;
  typedef logic signed [ERR_W-1:0] err_t;
  typedef logic [BEAT_W-1:0]     beat_t;

  typedef enum logic {
    OP_START   = 1'b0,
    OP_ADVANCE = 1'b1
  } opcode_t;

  typedef enum logic {
    CFG_CAMERA_X = 1'b0,
    CFG_CAMERA_Y = 1'b1
  } cfg_idx_t;

  // snapshot of one iteration handed from the state unit to the emitter
  typedef struct packed {
    logic   done;
    coord_t cx;
    coord_t cy;
    off_t   a;
    off_t   m;
  } job_t;

  // port value into internal coordinate width (zero-extend or truncate)
  function automatic coord_t port_to_coord(input logic [PORT_W-1:0] v);
    logic [COORD_BITS+PORT_W-1:0] w;
    begin
      w = {{COORD_BITS{1'b0}}, v};
      return w[COORD_BITS-1:0];
    end
  endfunction

  // internal coordinate back to port width
  function automatic logic [PORT_W-1:0] coord_to_port(input coord_t c);
    logic [COORD_BITS+PORT_W-1:0] w;
    begin
      w = {{PORT_W{1'b0}}, c};
      return w[PORT_W-1:0];
    end
  endfunction

  // offset into internal coordinate width
  function automatic coord_t off_to_coord(input off_t o);
    logic [COORD_BITS+OFF_W-1:0] w;
    begin
      w = {{COORD_BITS{1'b0}}, o};
      return w[COORD_BITS-1:0];
    end
  endfunction

endpackage

@@ sv/mcog_if.sv @@
// channel interfaces: input items, result items and configuration writes
interface mcog_in_if;
  logic               valid;
  logic               ready;
  logic               opcode;
  logic signed [15:0] center_x;
  logic signed [15:0] center_y;
  logic [13:0]        radius;

  modport source (output valid, opcode, center_x, center_y, radius, input ready);
  modport sink   (input valid, opcode, center_x, center_y, radius, output ready);
endinterface

interface mcog_out_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] point_x;
  logic signed [15:0] point_y;
  logic               point_valid;
  logic               last_of_step;
  logic               done_res;

  modport source (output valid, point_x, point_y, point_valid, last_of_step, done_res,
                  input ready);
  modport sink   (input valid, point_x, point_y, point_valid, last_of_step, done_res,
                  output ready);
endinterface

interface mcog_cfg_if;
  logic               valid;
  logic               ready;
  logic               index;
  logic signed [15:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

@@ sv/mcog_step.sv @@
// circle state: camera registers, shifted centre, offsets and decision error
module mcog_step (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         cfg_wr,
  input  logic                         cfg_index,
  input  logic [mcog_pkg::PORT_W-1:0]  cfg_data,
  input  logic                         item_take,
  input  logic                         item_opcode,
  input  logic [mcog_pkg::PORT_W-1:0]  item_cx,
  input  logic [mcog_pkg::PORT_W-1:0]  item_cy,
  input  logic [mcog_pkg::RADIUS_W-1:0] item_radius,
  output mcog_pkg::job_t               job
);
  import mcog_pkg::*;

  coord_t cam_x_r, cam_x_nxt;
  coord_t cam_y_r, cam_y_nxt;
  coord_t cx_r, cx_nxt;
  coord_t cy_r, cy_nxt;
  off_t   a_r, a_nxt;
  off_t   m_r, m_nxt;
  err_t   err_r, err_nxt;

  logic   done;
  off_t   m1;
  off_t   a_dec;
  err_t   err_sum;

  assign done    = !(a_r > m_r);
  assign m1      = m_r + OFF_W'(1);
  assign a_dec   = a_r - OFF_W'(1);
  assign err_sum = err_r + ERR_W'({m1, 1'b0});

  assign job = '{done: done, cx: cx_r, cy: cy_r, a: a_r, m: m_r};

  always_comb begin
    cam_x_nxt = cam_x_r;
    cam_y_nxt = cam_y_r;
    cx_nxt    = cx_r;
    cy_nxt    = cy_r;
    a_nxt     = a_r;
    m_nxt     = m_r;
    err_nxt   = err_r;
    if (cfg_wr) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_CAMERA_X: cam_x_nxt = port_to_coord(cfg_data);
        CFG_CAMERA_Y: cam_y_nxt = port_to_coord(cfg_data);
        default: ;
      endcase
    end
    if (item_take) begin
      unique case (opcode_t'(item_opcode))
        OP_START: begin
          cx_nxt  = port_to_coord(item_cx) - cam_x_r;
          cy_nxt  = port_to_coord(item_cy) - cam_y_r;
          a_nxt   = OFF_W'(item_radius);
          m_nxt   = '0;
          err_nxt = ERR_W'(0) - ERR_W'(item_radius);
        end
        OP_ADVANCE: begin
          if (!done) begin
            m_nxt   = m1;
            err_nxt = err_sum;
            if (!err_sum[ERR_W-1]) begin
              a_nxt   = a_dec;
              err_nxt = err_sum - (ERR_W'({a_dec, 1'b0}) - ERR_W'(1));
            end
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cam_x_r <= '0;
      cam_y_r <= '0;
      cx_r    <= '0;
      cy_r    <= '0;
      a_r     <= '0;
      m_r     <= '0;
      err_r   <= '0;
    end else begin
      cam_x_r <= cam_x_nxt;
      cam_y_r <= cam_y_nxt;
      cx_r    <= cx_nxt;
      cy_r    <= cy_nxt;
      a_r     <= a_nxt;
      m_r     <= m_nxt;
      err_r   <= err_nxt;
    end
  end

`ifndef SYNTHESIS
  // minor offset never overtakes the major offset by more than one
  a_minor_bound: assert property (@(posedge clk) disable iff (!rst_n)
    ({1'b0, m_r} <= {1'b0, a_r} + (OFF_W+1)'(1)))
    else $error("minor offset ran past major offset");
`endif

endmodule

@@ sv/mcog_emit.sv @@
// result register: holds one iteration and plays out its eight points, or a single done result
module mcog_emit (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           load,
  input  mcog_pkg::job_t job,
  output logic           free,
  mcog_out_if.source     out_chan
);
  import mcog_pkg::*;

  logic   busy_r, busy_nxt;
  beat_t  beat_r, beat_nxt;
  job_t   job_r, job_nxt;

  logic   last;
  logic   xfer;
  coord_t am1, neg_a, m1, neg_m1, mm;
  coord_t x_term, y_term;

  assign last = job_r.done || (beat_r == BEAT_LAST);
  assign xfer = out_chan.valid && out_chan.ready;
  assign free = !busy_r || (out_chan.ready && last);

  assign mm     = off_to_coord(job_r.m);
  assign am1    = off_to_coord(job_r.a) - COORD_BITS'(1);
  assign neg_a  = COORD_BITS'(0) - off_to_coord(job_r.a);
  assign m1     = mm + COORD_BITS'(1);
  assign neg_m1 = COORD_BITS'(0) - m1;

  // octant order of the eight symmetric points
  always_comb begin
    unique case (beat_r)
      3'd0:    begin x_term = am1;    y_term = mm;     end
      3'd1:    begin x_term = mm;     y_term = am1;    end
      3'd2:    begin x_term = neg_a;  y_term = mm;     end
      3'd3:    begin x_term = mm;     y_term = neg_a;  end
      3'd4:    begin x_term = am1;    y_term = neg_m1; end
      3'd5:    begin x_term = neg_m1; y_term = am1;    end
      3'd6:    begin x_term = neg_a;  y_term = neg_m1; end
      default: begin x_term = neg_m1; y_term = neg_a;  end
    endcase
  end

  assign out_chan.valid        = busy_r;
  assign out_chan.point_x      = job_r.done ? '0 : coord_to_port(job_r.cx + x_term);
  assign out_chan.point_y      = job_r.done ? '0 : coord_to_port(job_r.cy + y_term);
  assign out_chan.point_valid  = !job_r.done;
  assign out_chan.last_of_step = last;
  assign out_chan.done_res     = job_r.done;

  always_comb begin
    busy_nxt = busy_r;
    beat_nxt = beat_r;
    job_nxt  = job_r;
    if (xfer) begin
      if (last) begin
        busy_nxt = 1'b0;
      end else begin
        beat_nxt = beat_r + BEAT_W'(1);
      end
    end
    if (load) begin
      busy_nxt = 1'b1;
      beat_nxt = '0;
      job_nxt  = job;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      beat_r <= '0;
    end else begin
      busy_r <= busy_nxt;
      beat_r <= beat_nxt;
    end
  end

  always_ff @(posedge clk) begin
    job_r <= job_nxt;
  end

`ifndef SYNTHESIS
  a_done_single: assert property (@(posedge clk) disable iff (!rst_n)
    (busy_r && job_r.done) |-> (beat_r == '0))
    else $error("done result not on first beat");
  a_beat_step: assert property (@(posedge clk) disable iff (!rst_n)
    (xfer && !last && !load) |=> (busy_r && beat_r == $past(beat_r) + BEAT_W'(1)))
    else $error("beat counter skipped");
  a_load_busy: assert property (@(posedge clk) disable iff (!rst_n)
    load |=> (busy_r && beat_r == '0))
    else $error("loaded iteration not started");
  a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
    load |-> (!busy_r || (xfer && last)))
    else $error("iteration loaded over a pending one");
`endif

endmodule

@@ sv/midpoint_circle_outline_generator.sv @@
// top level of the midpoint circle outline generator
// A start transfer (opcode 0) loads a circle: the centre, less the camera
// offsets, and a whole-pixel radius; it gives no result. Each advance transfer
// (opcode 1) runs one midpoint iteration and gives eight outline points, one
// result transfer per cycle while the result side is ready, with last_of_step
// on the eighth; an advance once the outline is finished (or before any start)
// gives one done result instead. The state update happens in the cycle the
// advance is taken, and the iteration is parked in a result register that
// plays out the points, so the next item is taken in the cycle the last point
// leaves: with the result side always ready the block sustains a done advance
// or a start every cycle. The input is held off only while that result
// register is still playing out an iteration. Coordinates wrap at 16 bits.
// Camera registers are written through the configuration channel, which is
// always ready, and are meant to change only while no results are pending.
module midpoint_circle_outline_generator (
  input  logic        clk,
  input  logic        rst_n,
  mcog_in_if.sink     in_chan,
  mcog_out_if.source  out_chan,
  mcog_cfg_if.sink    cfg_chan
);
  import mcog_pkg::*;

  logic  emit_free;
  logic  in_take;
  logic  adv_load;
  logic  cfg_wr;
  job_t  job;

  // input taken whenever the result register can accept a new iteration
  assign in_chan.ready = emit_free;
  assign in_take       = in_chan.valid && in_chan.ready;
  assign adv_load      = in_take && (opcode_t'(in_chan.opcode) == OP_ADVANCE);

  // camera writes always land at once
  assign cfg_chan.ready = 1'b1;
  assign cfg_wr         = cfg_chan.valid && cfg_chan.ready;

  mcog_step u_step (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr      (cfg_wr),
    .cfg_index   (cfg_chan.index),
    .cfg_data    (cfg_chan.data),
    .item_take   (in_take),
    .item_opcode (in_chan.opcode),
    .item_cx     (in_chan.center_x),
    .item_cy     (in_chan.center_y),
    .item_radius (in_chan.radius),
    .job         (job)
  );

  mcog_emit u_emit (
    .clk      (clk),
    .rst_n    (rst_n),
    .load     (adv_load),
    .job      (job),
    .free     (emit_free),
    .out_chan (out_chan)
  );

endmodule

@@ dv/testbench.sv @@
// self-checking testbench of the midpoint circle outline generator
`timescale 1ns / 100ps

module testbench;
  import mcog_pkg::*;

  localparam int CLK_PERIOD     = 8;
  localparam int RESET_CYCLES   = 9;
  // cycles let pass once the last result is in, covers a trailing start
  localparam int SETTLE_CYCLES  = 16;
  // cycles with no transfer on any channel before the run is abandoned
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int PHASE_ITEMS    = 48;

  // one item as offered on the input channel
  typedef struct {
    opcode_t     op;
    logic [15:0] cx;
    logic [15:0] cy;
    logic [13:0] r;
  } circle_item_t;

  // one result transfer as it should appear on the output channel
  typedef struct {
    logic [15:0] x;
    logic [15:0] y;
    logic        valid;
    logic        last;
    logic        done;
  } outline_point_t;

  logic clk = 1'b0;
  logic rst_n;

  mcog_in_if  in_chan ();
  mcog_out_if out_chan ();
  mcog_cfg_if cfg_chan ();

  midpoint_circle_outline_generator u_top (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan),
    .out_chan (out_chan),
    .cfg_chan (cfg_chan)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  // stimulus waiting for the driver, and points still owed by the block
  circle_item_t   pending_items[$];
  outline_point_t outline_points[$];

  int send_idle_pct;
  int recv_stall_pct;
  int mismatch_count;
  int quiet_cycles;
  logic in_took;
  circle_item_t next_item;
  circle_item_t seen_item;
  outline_point_t want;

  // predictor state: camera registers, shifted centre, half-pixel offsets
  logic [15:0] camera_x_q;
  logic [15:0] camera_y_q;
  coord_t      origin_x;
  coord_t      origin_y;
  off_t        reach;       // x offset plus one half
  off_t        rise;        // y offset minus one half
  err_t        bend_error;

  task automatic report_mismatch(input string what, input int got, input int exp_val);
    $display("mismatch %s: got %0h expected %0h at %0t", what, got, exp_val, $time);
    mismatch_count++;
  endtask

  // work out what one accepted item does to the circle state and the results
  task automatic predict_outline_step(input circle_item_t it);
    coord_t xs[8];
    coord_t ys[8];
    coord_t ac;
    coord_t am1c;
    coord_t mc;
    coord_t m1c;
    outline_point_t p;
    if (it.op == OP_START) begin
      // camera taken off the centre once only
      origin_x   = it.cx - camera_x_q;
      origin_y   = it.cy - camera_y_q;
      reach      = off_t'(it.r);
      rise       = '0;
      bend_error = err_t'(-int'(it.r));
    end else if (reach <= rise) begin
      // outline already closed (also the state straight out of reset)
      p = '{x: '0, y: '0, valid: 1'b0, last: 1'b1, done: 1'b1};
      outline_points.push_back(p);
    end else begin
      ac   = coord_t'(reach);
      am1c = ac - coord_t'(1);
      mc   = coord_t'(rise);
      m1c  = mc + coord_t'(1);
      // eight octants in the block's emission order
      xs = '{origin_x + am1c, origin_x + mc,   origin_x - ac,  origin_x + mc,
             origin_x + am1c, origin_x - m1c,  origin_x - ac,  origin_x - m1c};
      ys = '{origin_y + mc,   origin_y + am1c, origin_y + mc,  origin_y - ac,
             origin_y - m1c,  origin_y + am1c, origin_y - m1c, origin_y - ac};
      for (int k = 0; k < NUM_BEATS; k++) begin
        p = '{x: xs[k], y: ys[k], valid: 1'b1, last: (k == NUM_BEATS - 1), done: 1'b0};
        outline_points.push_back(p);
      end
      bend_error = err_t'(int'(bend_error) + 2 * int'(rise) + 2);
      rise = rise + off_t'(1);
      if (bend_error >= 0) begin
        reach = reach - off_t'(1);
        bend_error = err_t'(int'(bend_error) - 2 * int'(reach) + 1);
      end
    end
  endtask

  // input driver: new payload at the falling edge once the last one went across
  always @(negedge clk) begin
    if (!rst_n) begin
      in_chan.valid <= 1'b0;
    end else if (!in_chan.valid || in_took) begin
      if (pending_items.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        next_item = pending_items.pop_front();
        in_chan.valid    <= 1'b1;
        in_chan.opcode   <= next_item.op;
        in_chan.center_x <= next_item.cx;
        in_chan.center_y <= next_item.cy;
        in_chan.radius   <= next_item.r;
      end else begin
        in_chan.valid <= 1'b0;
      end
    end
  end

  // result side back-pressure
  always @(negedge clk) begin
    out_chan.ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // monitor: predict on each input transfer, then check each result transfer
  always @(posedge clk) begin
    in_took <= rst_n && in_chan.valid && in_chan.ready;
    if (rst_n && in_chan.valid && in_chan.ready) begin
      seen_item.op = opcode_t'(in_chan.opcode);
      seen_item.cx = in_chan.center_x;
      seen_item.cy = in_chan.center_y;
      seen_item.r  = in_chan.radius;
      predict_outline_step(seen_item);
    end
    if (rst_n && out_chan.valid && out_chan.ready) begin
      if (outline_points.size() == 0) begin
        report_mismatch("unexpected result, point_x", out_chan.point_x, 0);
      end else begin
        want = outline_points.pop_front();
        if (out_chan.point_x !== want.x)
          report_mismatch("point_x", out_chan.point_x, want.x);
        if (out_chan.point_y !== want.y)
          report_mismatch("point_y", out_chan.point_y, want.y);
        if (out_chan.point_valid !== want.valid)
          report_mismatch("point_valid", out_chan.point_valid, want.valid);
        if (out_chan.last_of_step !== want.last)
          report_mismatch("last_of_step", out_chan.last_of_step, want.last);
        if (out_chan.done_res !== want.done)
          report_mismatch("done_res", out_chan.done_res, want.done);
      end
    end
  end

  // watchdog: any transfer on any channel counts as progress
  always @(posedge clk) begin
    if (!rst_n || (in_chan.valid && in_chan.ready) || (out_chan.valid && out_chan.ready)
        || (cfg_chan.valid && cfg_chan.ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("testbench failed");
      $finish;
    end
  end

  task automatic push_start(input logic [15:0] cx, input logic [15:0] cy,
                            input logic [13:0] r);
    circle_item_t it;
    it = '{op: OP_START, cx: cx, cy: cy, r: r};
    pending_items.push_back(it);
  endtask

  // advance items carry random filler in the unused fields
  task automatic push_advance(input int count);
    circle_item_t it;
    for (int k = 0; k < count; k++) begin
      it = '{op: OP_ADVANCE, cx: 16'($urandom), cy: 16'($urandom), r: 14'($urandom)};
      pending_items.push_back(it);
    end
  endtask

  // hold the sender until the block has nothing owed, then let it settle
  task automatic wait_drained();
    @(posedge clk);
    while (pending_items.size() != 0 || in_chan.valid || outline_points.size() != 0)
      @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_camera(input cfg_idx_t idx, input logic [15:0] value);
    @(negedge clk);
    cfg_chan.valid <= 1'b1;
    cfg_chan.index <= idx;
    cfg_chan.data  <= value;
    @(posedge clk);
    while (!cfg_chan.ready) @(posedge clk);
    if (idx == CFG_CAMERA_X) begin
      camera_x_q = value;
    end else begin
      camera_y_q = value;
    end
    @(negedge clk);
    cfg_chan.valid <= 1'b0;
  endtask

  // mostly whole circles with small radii traced to the done result,
  // some huge circles cut short, some broken sequences and some noise
  task automatic queue_random_items(input int count);
    int added;
    int roll;
    int r;
    int steps;
    int a;
    int m;
    int e;
    circle_item_t it;
    added = 0;
    while (added < count) begin
      roll = $urandom_range(99);
      if (roll < 10) begin
        it = '{op: opcode_t'($urandom_range(1)), cx: 16'($urandom), cy: 16'($urandom),
               r: 14'($urandom)};
        pending_items.push_back(it);
        added++;
      end else begin
        roll = $urandom_range(99);
        if (roll < 75) begin
          r = $urandom_range(0, 10);
        end else if (roll < 90) begin
          r = $urandom_range(11, 40);
        end else begin
          r = $urandom_range(0, 16383);
        end
        // iterations needed to close the outline
        a = r;
        m = 0;
        e = -r;
        steps = 0;
        while (a > m && steps < 64) begin
          e = e + 2 * m + 2;
          m++;
          if (e >= 0) begin
            a--;
            e = e - 2 * a + 1;
          end
          steps++;
        end
        if (r > 40) begin
          steps = $urandom_range(1, 3);
        end else if ($urandom_range(99) < 12) begin
          steps = $urandom_range(0, 2);      // restarted before the outline closes
        end else begin
          steps = steps + 1;                 // one extra for the done result
        end
        push_start(16'($urandom), 16'($urandom), 14'(r));
        push_advance(steps);
        added += steps + 1;
      end
    end
  endtask

  initial begin
    rst_n            = 1'b0;
    in_chan.valid    = 1'b0;
    in_chan.opcode   = OP_START;
    in_chan.center_x = '0;
    in_chan.center_y = '0;
    in_chan.radius   = '0;
    out_chan.ready   = 1'b0;
    cfg_chan.valid   = 1'b0;
    cfg_chan.index   = CFG_CAMERA_X;
    cfg_chan.data    = '0;
    send_idle_pct    = 0;
    recv_stall_pct   = 0;
    mismatch_count   = 0;
    quiet_cycles     = 0;
    in_took          = 1'b0;
    camera_x_q       = '0;
    camera_y_q       = '0;
    origin_x         = '0;
    origin_y         = '0;
    reach            = '0;
    rise             = '0;
    bend_error       = '0;

    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // advance straight out of reset gives the done result
    push_advance(1);
    // zero radius is closed at once
    push_start(16'h0000, 16'h0000, 14'd0);
    push_advance(1);
    // radius one at the extreme corner: one iteration then done
    push_start(16'h7fff, 16'h8000, 14'd1);
    push_advance(2);
    // largest radius on the opposite corner, coordinates wrap
    push_start(16'h8000, 16'h7fff, 14'h3fff);
    push_advance(3);
    // alternating bit patterns in every field
    push_start(16'h5555, 16'haaaa, 14'h2aaa);
    push_advance(1);
    push_start(16'haaaa, 16'h5555, 14'h1555);
    push_advance(1);
    // radius two closes after a single iteration
    push_start(16'hffff, 16'h0001, 14'd2);
    push_advance(2);
    wait_drained();

    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin
          write_camera(CFG_CAMERA_X, 16'h8000);
          write_camera(CFG_CAMERA_Y, 16'h7fff);
        end
        1: begin
          write_camera(CFG_CAMERA_X, 16'h7fff);
          write_camera(CFG_CAMERA_Y, 16'h8000);
        end
        default: begin
          write_camera(CFG_CAMERA_X, 16'($urandom));
          write_camera(CFG_CAMERA_Y, 16'($urandom));
        end
      endcase
      case (phase)
        0: begin
          send_idle_pct  = 0;
          recv_stall_pct = 0;
        end
        1: begin
          send_idle_pct  = 88;
          recv_stall_pct = 0;
        end
        2: begin
          send_idle_pct  = 0;
          recv_stall_pct = 88;
        end
        default: begin
          send_idle_pct  = 36;
          recv_stall_pct = 36;
        end
      endcase
      if (phase == 0) begin
        // sender held back mid-phase until every owed point is out
        queue_random_items(PHASE_ITEMS / 2);
        wait_drained();
        queue_random_items(PHASE_ITEMS / 2);
      end else begin
        queue_random_items(PHASE_ITEMS);
      end
      wait_drained();
    end

    if (mismatch_count == 0) begin
      $display("testbench passed");
    end else begin
      $display("testbench failed");
    end
    $finish;
  end

endmodule

@@ sim.f @@
sv/mcog_pkg.sv
sv/mcog_if.sv
sv/mcog_step.sv
sv/mcog_emit.sv
sv/midpoint_circle_outline_generator.sv
dv/testbench.sv
